/* hdl/cbws_pkg.sv */
// ============================================================================
// cbws_pkg
// Shared widths, codes and types of the cost-based worker selector.
// ============================================================================
package cbws_pkg;

    localparam int MAX_WORKERS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int CMD_W    = 2;
    localparam int IDX_W    = 4;
    localparam int ID_W     = 64;
    localparam int KV_W     = 20;
    localparam int SL_W     = 16;
    localparam int WCNT_W   = 5;
    localparam int OV_W     = 20;
    localparam int ISL_W    = 20;
    localparam int BS_W     = 16;
    localparam int STATUS_W = 2;

    localparam logic [BS_W-1:0] BLOCK_SIZE_RESET = 16'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_COMMIT  = 2'd1,
        CMD_OVERLAP = 2'd2,
        CMD_SCHED   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_BUSY = 2'd2
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [KV_W-1:0] kv_used;
        logic [KV_W-1:0] kv_cap;
        logic [SL_W-1:0] sl_used;
        logic [SL_W-1:0] sl_cap;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CMT_RD,
        S_CMT_LD,
        S_CMT_DIV,
        S_CMT_WAIT,
        S_CMT_SQ,
        S_CMT_ACC,
        S_MEAN_DIV,
        S_MEAN_WAIT,
        S_BAL_MUL,
        S_BAL_SCALE,
        S_BAL_CMP,
        S_SCH_RD,
        S_SCH_LD,
        S_SCH_MUL,
        S_SCH_NEW,
        S_SCH_WAIT,
        S_SCH_COST,
        S_BLK_DIV,
        S_BLK_WAIT,
        S_BUMP,
        S_DONE
    } t_state;

endpackage

/* hdl/cbws_ram.sv */
// ============================================================================
// cbws_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module cbws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/cbws_div.sv */
// ============================================================================
// cbws_div
// Restoring divider, one quotient bit per cycle. A zero divisor gives zero.
// ============================================================================
module cbws_div #(
    parameter int DW = 36,
    parameter int VW = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_num,
    input  logic [VW-1:0] i_den,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic          r_zero;
    logic [VW-1:0] r_den;
    logic [VW-1:0] r_rem;
    logic [DW-1:0] r_q;
    logic [VW:0]   w_sh;
    logic          w_ge;

    assign w_sh = {r_rem, r_q[DW-1]};
    assign w_ge = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_q <= {r_q[DW-2:0], w_ge};
            if (w_ge) begin
                r_rem <= VW'(w_sh - {1'b0, r_den});
            end else begin
                r_rem <= w_sh[VW-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : r_q;

endmodule

/* hdl/cost_based_worker_selector.sv */
// ============================================================================
// cost_based_worker_selector
// Keeps a worker table in RAM, computes load statistics on commit and picks
// the lowest-cost worker on schedule.
// ============================================================================
// Commit and schedule words run their divisions on bit-serial dividers. One word
// is in work at a time.
// Reset clears the table valid bits, the snapshot state and block_size (64).
module cost_based_worker_selector
    import cbws_pkg::*;
#(
    parameter int MAX_WORKERS = MAX_WORKERS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [BS_W-1:0]     i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [IDX_W-1:0]    i_index,
    input  logic [ID_W-1:0]     i_worker_id,
    input  logic [KV_W-1:0]     i_kv_used,
    input  logic [KV_W-1:0]     i_kv_capacity,
    input  logic [SL_W-1:0]     i_slots_used,
    input  logic [SL_W-1:0]     i_slots_capacity,
    input  logic [WCNT_W-1:0]   i_worker_count,
    input  logic [OV_W-1:0]     i_overlap_score,
    input  logic [ISL_W-1:0]    i_isl_tokens,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [ID_W-1:0]     o_chosen_worker,
    output logic [ISL_W-1:0]    o_req_blocks,
    output logic [OV_W-1:0]     o_hit_blocks
);

    localparam int AW   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CNTW = $clog2(MAX_WORKERS + 1);
    localparam int F    = FRAC_BITS;
    localparam int DW   = KV_W + F;
    localparam int LW   = F + 1;
    localparam int SUMW = LW + CNTW;
    localparam int D2W  = 2 * LW + CNTW;
    localparam int CMPW = D2W + 7;
    localparam int CW   = F + 6;
    localparam int OVTW = OV_W + BS_W;
    localparam int EW   = $bits(t_entry);

    localparam logic [LW-1:0] ONE = {1'b1, {F{1'b0}}};
    localparam logic signed [CW-1:0] K3 = CW'(3);
    localparam logic signed [CW-1:0] K7 = CW'(7);

    t_state r_state, n_state;

    logic [BS_W-1:0]        r_block_size;
    logic [MAX_WORKERS-1:0] r_ent_vld;
    logic [MAX_WORKERS-1:0] r_ov_vld;
    logic [ISL_W-1:0]       r_isl;
    logic [CNTW-1:0]        r_wiu;
    logic [LW-1:0]          r_mean;
    logic                   r_flag;
    logic [AW-1:0]          r_idx;
    logic                   r_pass2;

    logic [ID_W-1:0]        r_id;
    logic [KV_W-1:0]        r_kv_u, r_kv_c;
    logic [SL_W-1:0]        r_sl_u, r_sl_c;
    logic [OV_W-1:0]        r_ov;
    logic [OVTW-1:0]        r_ov_tok;

    logic [SUMW-1:0]        r_sum;
    logic [LW-1:0]          r_d;
    logic [2*LW-1:0]        r_sq;
    logic [D2W-1:0]         r_dev2;
    logic [CMPW-1:0]        r_a, r_b;

    logic [LW-1:0]          r_load_frac, r_new_frac, r_slot_frac;
    logic                   r_found;
    logic signed [CW-1:0]   r_min_cost;
    logic [AW-1:0]          r_best;
    t_entry                 r_best_ent;
    logic [OV_W-1:0]        r_best_ov;
    logic [ISL_W-1:0]       r_blocks;

    t_status                r_res_status;
    logic [ID_W-1:0]        r_res_id;
    logic [ISL_W-1:0]       r_res_blk;
    logic [OV_W-1:0]        r_res_ov;

    logic                   r_out_valid;
    t_status                r_out_status;
    logic [ID_W-1:0]        r_out_id;
    logic [ISL_W-1:0]       r_out_blk;
    logic [OV_W-1:0]        r_out_ov;

    logic                   w_acc;
    t_cmd                   w_cmd;
    logic                   w_in_range;
    logic [AW+IDX_W-1:0]    w_index_ext;
    logic [AW-1:0]          w_waddr_in;
    logic [CNTW-1:0]        w_n;
    logic                   w_last;
    logic                   w_out_free;

    logic                   w_ent_we;
    logic [AW-1:0]          w_ent_waddr;
    t_entry                 w_ent_wdata;
    t_entry                 w_ent_q, w_ent;
    logic                   w_ov_we;
    logic [OV_W-1:0]        w_ov_q, w_ov;

    logic                   w_a_start, w_bc_start;
    logic [DW-1:0]          w_a_num;
    logic [KV_W-1:0]        w_a_den;
    logic                   w_a_done;
    logic [DW-1:0]          w_qa, w_qb, w_qc;
    logic                   w_b_done, w_c_done;
    logic [ISL_W-1:0]       w_new_tok;
    logic [LW-1:0]          w_load;
    logic signed [CW-1:0]   w_dev, w_newf, w_slotf, w_cost;
    logic                   w_full;

    assign w_acc       = i_in_valid && o_in_ready;
    assign w_cmd       = t_cmd'(i_cmd);
    assign w_in_range  = ({28'd0, i_index} < 32'(MAX_WORKERS));
    assign w_index_ext = (AW + IDX_W)'(i_index);
    assign w_waddr_in  = w_index_ext[AW-1:0];
    assign w_n = ({27'd0, i_worker_count} > 32'(MAX_WORKERS)) ? CNTW'(MAX_WORKERS)
                                                               : CNTW'(i_worker_count);
    assign w_last     = ((CNTW'(r_idx) + CNTW'(1)) == r_wiu);
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_ent = r_ent_vld[r_idx] ? w_ent_q : '0;
    assign w_ov  = r_ov_vld[r_idx] ? w_ov_q : '0;

    assign w_full = (r_sl_u >= r_sl_c) || (r_kv_u >= r_kv_c);
    assign w_new_tok = (OVTW'(r_isl) > r_ov_tok) ? ISL_W'(OVTW'(r_isl) - r_ov_tok) : '0;
    assign w_load = (w_qa > DW'(ONE)) ? ONE : w_qa[LW-1:0];

    assign w_dev   = $signed(CW'(r_load_frac)) - $signed(CW'(r_mean));
    assign w_newf  = $signed(CW'(r_new_frac));
    assign w_slotf = $signed(CW'(r_slot_frac));
    assign w_cost  = r_flag ? (w_dev * K7 + w_newf * K3 + w_slotf)
                            : (w_dev * K3 + w_newf * K7 + w_slotf);

    cbws_ram #(.WIDTH(EW), .DEPTH(MAX_WORKERS)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (w_ent_waddr),
        .i_wdata (w_ent_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_ent_q)
    );

    cbws_ram #(.WIDTH(OV_W), .DEPTH(MAX_WORKERS)) u_ov_ram (
        .i_clk   (i_clk),
        .i_we    (w_ov_we),
        .i_waddr (w_waddr_in),
        .i_wdata (i_overlap_score),
        .i_raddr (r_idx),
        .o_rdata (w_ov_q)
    );

    cbws_div #(.DW(DW), .VW(KV_W)) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_a_start),
        .i_num   (w_a_num),
        .i_den   (w_a_den),
        .o_done  (w_a_done),
        .o_quot  (w_qa)
    );

    cbws_div #(.DW(DW), .VW(KV_W)) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bc_start),
        .i_num   (DW'(w_new_tok) << F),
        .i_den   (r_isl),
        .o_done  (w_b_done),
        .o_quot  (w_qb)
    );

    cbws_div #(.DW(DW), .VW(KV_W)) u_div_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bc_start),
        .i_num   (DW'(r_sl_u) << F),
        .i_den   (KV_W'(r_sl_c)),
        .o_done  (w_c_done),
        .o_quot  (w_qc)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (w_cmd)
                        CMD_COMMIT: n_state = (w_n == '0) ? S_DONE : S_CMT_RD;
                        CMD_SCHED:  n_state = (r_wiu == '0) ? S_DONE : S_SCH_RD;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_CMT_RD:  n_state = S_CMT_LD;
            S_CMT_LD:  n_state = S_CMT_DIV;
            S_CMT_DIV: n_state = S_CMT_WAIT;
            S_CMT_WAIT: begin
                if (w_a_done) begin
                    if (r_pass2) begin
                        n_state = S_CMT_SQ;
                    end else begin
                        n_state = w_last ? S_MEAN_DIV : S_CMT_RD;
                    end
                end
            end
            S_CMT_SQ:    n_state = S_CMT_ACC;
            S_CMT_ACC:   n_state = w_last ? S_BAL_MUL : S_CMT_RD;
            S_MEAN_DIV:  n_state = S_MEAN_WAIT;
            S_MEAN_WAIT: n_state = w_a_done ? S_CMT_RD : S_MEAN_WAIT;
            S_BAL_MUL:   n_state = S_BAL_SCALE;
            S_BAL_SCALE: n_state = S_BAL_CMP;
            S_BAL_CMP:   n_state = S_DONE;
            S_SCH_RD:    n_state = S_SCH_LD;
            S_SCH_LD:    n_state = S_SCH_MUL;
            S_SCH_MUL:   n_state = S_SCH_NEW;
            S_SCH_NEW: begin
                if (w_full) begin
                    n_state = w_last ? S_BLK_DIV : S_SCH_RD;
                end else begin
                    n_state = S_SCH_WAIT;
                end
            end
            S_SCH_WAIT:  n_state = (w_a_done && w_b_done && w_c_done) ? S_SCH_COST
                                                                      : S_SCH_WAIT;
            S_SCH_COST:  n_state = w_last ? S_BLK_DIV : S_SCH_RD;
            S_BLK_DIV:   n_state = r_found ? S_BLK_WAIT : S_DONE;
            S_BLK_WAIT:  n_state = w_a_done ? S_BUMP : S_BLK_WAIT;
            S_BUMP:      n_state = S_DONE;
            S_DONE:      n_state = w_out_free ? S_IDLE : S_DONE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Memory and divider controls.
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        w_ent_we    = 1'b0;
        w_ent_waddr = w_waddr_in;
        w_ent_wdata = '{id: i_worker_id, kv_used: i_kv_used, kv_cap: i_kv_capacity,
                        sl_used: i_slots_used, sl_cap: i_slots_capacity};
        w_ov_we     = 1'b0;
        w_a_start   = 1'b0;
        w_bc_start  = 1'b0;
        w_a_num     = DW'(r_kv_u) << F;
        w_a_den     = r_kv_c;
        case (r_state)
            S_IDLE: begin
                w_ent_we = i_in_valid && (w_cmd == CMD_WRITE) && w_in_range;
                w_ov_we  = i_in_valid && (w_cmd == CMD_OVERLAP) && w_in_range;
            end
            S_CMT_DIV: w_a_start = 1'b1;
            S_MEAN_DIV: begin
                w_a_start = 1'b1;
                w_a_num   = DW'(r_sum);
                w_a_den   = KV_W'(r_wiu);
            end
            S_SCH_NEW: begin
                w_a_start  = !w_full;
                w_bc_start = !w_full;
            end
            S_BLK_DIV: begin
                w_a_start = r_found;
                w_a_num   = DW'(r_isl);
                w_a_den   = KV_W'(r_block_size);
            end
            S_BUMP: begin
                w_ent_we    = 1'b1;
                w_ent_waddr = r_best;
                w_ent_wdata = r_best_ent;
                w_ent_wdata.sl_used = r_best_ent.sl_used + 1'b1;
                w_ent_wdata.kv_used = r_best_ent.kv_used + KV_W'(r_blocks != '0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_block_size <= BLOCK_SIZE_RESET;
            r_ent_vld    <= '0;
            r_ov_vld     <= '0;
            r_wiu        <= '0;
            r_mean       <= '0;
            r_flag       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_block_size <= i_cfg_data;
            end
            if (w_ent_we) begin
                r_ent_vld[w_ent_waddr] <= 1'b1;
            end
            if (w_ov_we) begin
                r_ov_vld[w_waddr_in] <= 1'b1;
            end
            if (r_state == S_IDLE && w_acc && w_cmd == CMD_SCHED && r_wiu == '0) begin
                r_ov_vld <= '0;
            end
            if (r_state == S_BLK_DIV || r_state == S_BUMP) begin
                r_ov_vld <= '0;
            end
            if (r_state == S_IDLE && w_acc && w_cmd == CMD_COMMIT) begin
                r_wiu <= w_n;
                if (w_n == '0) begin
                    r_mean <= '0;
                    r_flag <= 1'b0;
                end
            end
            if (r_state == S_MEAN_WAIT && w_a_done) begin
                r_mean <= w_qa[LW-1:0];
            end
            if (r_state == S_BAL_CMP) begin
                r_flag <= (r_a > r_b);
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx        <= '0;
                r_pass2      <= 1'b0;
                r_sum        <= '0;
                r_dev2       <= '0;
                r_found      <= 1'b0;
                r_isl        <= i_isl_tokens;
                r_res_status <= (w_cmd == CMD_SCHED && r_wiu == '0) ? ST_NONE : ST_OK;
                r_res_id     <= '0;
                r_res_blk    <= '0;
                r_res_ov     <= '0;
            end
            S_CMT_LD: begin
                r_kv_u <= w_ent.kv_used;
                r_kv_c <= w_ent.kv_cap;
            end
            S_CMT_WAIT: begin
                if (w_a_done) begin
                    if (r_pass2) begin
                        r_d <= (w_load > r_mean) ? (w_load - r_mean) : (r_mean - w_load);
                    end else begin
                        r_sum <= r_sum + SUMW'(w_load);
                        r_idx <= w_last ? r_idx : AW'(r_idx + 1'b1);
                    end
                end
            end
            S_CMT_SQ:  r_sq <= r_d * r_d;
            S_CMT_ACC: begin
                r_dev2 <= r_dev2 + D2W'(r_sq);
                r_idx  <= AW'(r_idx + 1'b1);
            end
            S_MEAN_WAIT: begin
                if (w_a_done) begin
                    r_idx   <= '0;
                    r_pass2 <= 1'b1;
                end
            end
            S_BAL_MUL: begin
                r_a  <= CMPW'(r_dev2) * CMPW'(100);
                r_sq <= r_mean * r_mean;
            end
            S_BAL_SCALE: r_b <= CMPW'(r_sq) * CMPW'(r_wiu);
            S_SCH_LD: begin
                r_id   <= w_ent.id;
                r_kv_u <= w_ent.kv_used;
                r_kv_c <= w_ent.kv_cap;
                r_sl_u <= w_ent.sl_used;
                r_sl_c <= w_ent.sl_cap;
                r_ov   <= w_ov;
            end
            S_SCH_MUL: r_ov_tok <= r_ov * r_block_size;
            S_SCH_NEW: begin
                if (w_full && !w_last) begin
                    r_idx <= AW'(r_idx + 1'b1);
                end
            end
            S_SCH_WAIT: begin
                r_load_frac <= w_qa[LW-1:0];
                r_new_frac  <= w_qb[LW-1:0];
                r_slot_frac <= w_qc[LW-1:0];
            end
            S_SCH_COST: begin
                if (!r_found || w_cost < r_min_cost) begin
                    r_found     <= 1'b1;
                    r_min_cost  <= w_cost;
                    r_best      <= r_idx;
                    r_best_ent  <= '{id: r_id, kv_used: r_kv_u, kv_cap: r_kv_c,
                                     sl_used: r_sl_u, sl_cap: r_sl_c};
                    r_best_ov   <= r_ov;
                end
                if (!w_last) begin
                    r_idx <= AW'(r_idx + 1'b1);
                end
            end
            S_BLK_DIV: begin
                if (!r_found) begin
                    r_res_status <= ST_BUSY;
                end
            end
            S_BLK_WAIT: r_blocks <= w_qa[ISL_W-1:0];
            S_BUMP: begin
                r_res_status <= ST_OK;
                r_res_id     <= r_best_ent.id;
                r_res_blk    <= r_blocks;
                r_res_ov     <= r_best_ov;
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_status <= r_res_status;
                    r_out_id     <= r_res_id;
                    r_out_blk    <= r_res_blk;
                    r_out_ov     <= r_res_ov;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_chosen_worker = r_out_id;
    assign o_req_blocks    = r_out_blk;
    assign o_hit_blocks    = r_out_ov;

endmodule

/* tb/sv/cost_based_worker_selector_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// cost_based_worker_selector_tb
// Drives table writes, overlap writes, commits and schedule requests with
// random idling on both sides. Every word that comes back is checked against
// a cycle-free model of the worker table, the snapshot and the cost choice.
// ============================================================================
module cost_based_worker_selector_tb;
    import cbws_pkg::*;

    localparam int NW = 16;
    localparam int FB = 16;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct {
        t_cmd             cmd;
        logic [IDX_W-1:0] idx;
        logic [ID_W-1:0]  id;
        logic [KV_W-1:0]  kvu;
        logic [KV_W-1:0]  kvc;
        logic [SL_W-1:0]  slu;
        logic [SL_W-1:0]  slc;
        logic [WCNT_W-1:0] cnt;
        logic [OV_W-1:0]  ov;
        logic [ISL_W-1:0] isl;
    } t_word;

    typedef struct {
        t_status          st;
        logic [ID_W-1:0]  id;
        logic [ISL_W-1:0] blk;
        logic [OV_W-1:0]  ov;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [BS_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [CMD_W-1:0] i_cmd = '0;
    logic [IDX_W-1:0] i_index = '0;
    logic [ID_W-1:0] i_worker_id = '0;
    logic [KV_W-1:0] i_kv_used = '0;
    logic [KV_W-1:0] i_kv_capacity = '0;
    logic [SL_W-1:0] i_slots_used = '0;
    logic [SL_W-1:0] i_slots_capacity = '0;
    logic [WCNT_W-1:0] i_worker_count = '0;
    logic [OV_W-1:0] i_overlap_score = '0;
    logic [ISL_W-1:0] i_isl_tokens = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0] o_chosen_worker;
    logic [ISL_W-1:0] o_req_blocks;
    logic [OV_W-1:0] o_hit_blocks;

    cost_based_worker_selector dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Model state of the worker table.
    logic [ID_W-1:0] m_id [NW];
    logic [KV_W-1:0] m_kvu [NW];
    logic [KV_W-1:0] m_kvc [NW];
    logic [SL_W-1:0] m_slu [NW];
    logic [SL_W-1:0] m_slc [NW];
    logic [OV_W-1:0] m_ov [NW];
    longint unsigned m_mean;
    bit m_balance;
    int m_in_use;
    logic [BS_W-1:0] m_block_size;

    t_word pending_words[$];
    t_reply expected_replies[$];
    int errors = 0;
    longint cycles = 0;

    function automatic longint unsigned q_frac(longint unsigned n, longint unsigned d);
        if (d == 0) return 0;
        return (n << FB) / d;
    endfunction

    function automatic longint unsigned cache_load(int i);
        longint unsigned r;
        r = q_frac(m_kvu[i], m_kvc[i]);
        return (r > (64'd1 << FB)) ? (64'd1 << FB) : r;
    endfunction

    function automatic t_reply apply_word(t_word w);
        t_reply r;
        longint unsigned sum, dev2, ld, d, ovt, newt, blocks;
        longint low_cost, cost, a10;
        int n, best;
        bit found;
        r = '{ST_OK, '0, '0, '0};
        case (w.cmd)
            CMD_WRITE: begin
                m_id[w.idx] = w.id; m_kvu[w.idx] = w.kvu; m_kvc[w.idx] = w.kvc;
                m_slu[w.idx] = w.slu; m_slc[w.idx] = w.slc;
            end
            CMD_OVERLAP: m_ov[w.idx] = w.ov;
            CMD_COMMIT: begin
                n = (w.cnt > NW) ? NW : int'(w.cnt);
                m_in_use = n;
                m_mean = 0;
                m_balance = 0;
                if (n > 0) begin
                    sum = 0; dev2 = 0;
                    for (int i = 0; i < n; i++) sum += cache_load(i);
                    m_mean = sum / n;
                    for (int i = 0; i < n; i++) begin
                        ld = cache_load(i);
                        d = (ld > m_mean) ? ld - m_mean : m_mean - ld;
                        dev2 += d * d;
                    end
                    m_balance = (dev2 * 100) > (longint'(n) * m_mean * m_mean);
                end
            end
            default: begin
                a10 = m_balance ? 7 : 3;
                found = 0; best = 0; low_cost = 0;
                for (int i = 0; i < m_in_use; i++) begin
                    if (m_slu[i] >= m_slc[i] || m_kvu[i] >= m_kvc[i]) continue;
                    ovt = longint'(m_ov[i]) * m_block_size;
                    newt = (w.isl > ovt) ? w.isl - ovt : 0;
                    cost = a10 * (longint'(q_frac(m_kvu[i], m_kvc[i])) - longint'(m_mean))
                         + (10 - a10) * longint'(q_frac(newt, w.isl))
                         + longint'(q_frac(m_slu[i], m_slc[i]));
                    if (!found || cost < low_cost) begin
                        found = 1; low_cost = cost; best = i;
                    end
                end
                if (m_in_use == 0) r.st = ST_NONE;
                else if (!found) r.st = ST_BUSY;
                else begin
                    blocks = (m_block_size == 0) ? 0 : w.isl / m_block_size;
                    m_slu[best] = m_slu[best] + 1'b1;
                    m_kvu[best] = m_kvu[best] + (blocks > 0);
                    r.id = m_id[best]; r.blk = blocks[ISL_W-1:0]; r.ov = m_ov[best];
                end
                for (int i = 0; i < NW; i++) m_ov[i] = '0;
            end
        endcase
        return r;
    endfunction

    // Driver: valid holds until accepted, then a random gap.
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_replies.insert(expected_replies.size(),
                                        apply_word(pending_words.pop_front()));
                in_gap = $urandom_range(0, 16);
                if ($urandom_range(0, 3) == 0) in_gap = 0;
            end
            if (!(i_in_valid && !o_in_ready)) begin
                if (in_gap == 0 && pending_words.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_cmd <= pending_words[0].cmd;
                    i_index <= pending_words[0].idx;
                    i_worker_id <= pending_words[0].id;
                    i_kv_used <= pending_words[0].kvu;
                    i_kv_capacity <= pending_words[0].kvc;
                    i_slots_used <= pending_words[0].slu;
                    i_slots_capacity <= pending_words[0].slc;
                    i_worker_count <= pending_words[0].cnt;
                    i_overlap_score <= pending_words[0].ov;
                    i_isl_tokens <= pending_words[0].isl;
                end else begin
                    i_in_valid <= 1'b0;
                    if (in_gap > 0) in_gap = in_gap - 1;
                end
            end
        end
    end

    // Monitor: random ready stalls and field checks.
    int out_gap = 0;
    t_reply exp_r;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_replies.size() == 0) begin
                    $error("unexpected word status=%0d", o_status);
                    errors++;
                end else begin
                    exp_r = expected_replies.pop_front();
                    if (o_status !== exp_r.st) begin
                        $error("status expected %0d actual %0d", exp_r.st, o_status); errors++;
                    end
                    if (o_chosen_worker !== exp_r.id) begin
                        $error("chosen_worker expected %0h actual %0h", exp_r.id,
                               o_chosen_worker); errors++;
                    end
                    if (o_req_blocks !== exp_r.blk) begin
                        $error("req_blocks expected %0d actual %0d", exp_r.blk,
                               o_req_blocks); errors++;
                    end
                    if (o_hit_blocks !== exp_r.ov) begin
                        $error("hit_blocks expected %0d actual %0d", exp_r.ov,
                               o_hit_blocks); errors++;
                    end
                end
                out_gap = $urandom_range(0, 16);
                if ($urandom_range(0, 3) == 0) out_gap = 0;
            end
            if (out_gap > 0) begin
                out_gap = out_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_word blank_word(t_cmd c);
        t_word w;
        w = '{c, '0, '0, '0, '0, '0, '0, '0, '0, '0};
        return w;
    endfunction

    function automatic t_word random_entry(int idx);
        t_word w;
        w = blank_word(CMD_WRITE);
        w.idx = IDX_W'(idx);
        w.id = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: begin
                w.kvc = KV_W'($urandom); w.kvu = KV_W'($urandom);
                w.slc = SL_W'($urandom); w.slu = SL_W'($urandom);
            end
            1: begin
                w.kvc = '0; w.kvu = KV_W'($urandom_range(0, 3));
                w.slc = SL_W'(4); w.slu = SL_W'(1);
            end
            default: begin
                w.kvc = KV_W'($urandom_range(1, 64));
                w.kvu = KV_W'($urandom_range(0, w.kvc + 1));
                w.slc = SL_W'($urandom_range(1, 8));
                w.slu = SL_W'($urandom_range(0, w.slc));
            end
        endcase
        return w;
    endfunction

    task automatic add_sched(logic [ISL_W-1:0] isl);
        t_word w;
        w = blank_word(CMD_SCHED);
        w.isl = isl;
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic add_commit(logic [WCNT_W-1:0] cnt);
        t_word w;
        w = blank_word(CMD_COMMIT);
        w.cnt = cnt;
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic add_overlap(int idx, logic [OV_W-1:0] ov);
        t_word w;
        w = blank_word(CMD_OVERLAP);
        w.idx = IDX_W'(idx); w.ov = ov;
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || i_in_valid || expected_replies.size() > 0)
            @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
    endtask

    task automatic write_block_size(logic [BS_W-1:0] bs);
        i_cfg_data <= bs;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        m_block_size = bs;
        @(posedge i_clk);
    endtask

    int n_words;
    logic [BS_W-1:0] bs_list [5] = '{16'd64, 16'd1, 16'd0, 16'hFFFF, 16'd16};
    t_word w;

    initial begin
        for (int i = 0; i < NW; i++) begin
            m_id[i] = 0; m_kvu[i] = 0; m_kvc[i] = 0; m_slu[i] = 0; m_slc[i] = 0; m_ov[i] = 0;
        end
        m_mean = 0; m_balance = 0; m_in_use = 0; m_block_size = BLOCK_SIZE_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty snapshot, extremes, full workers, overload, oversize count.
        add_sched(20'd100);
        add_commit(5'd0);
        add_sched(20'd0);
        w = blank_word(CMD_WRITE);
        w.idx = 4'd0; w.id = '1; w.kvu = '1; w.kvc = '1; w.slu = '1; w.slc = '1;
        pending_words.insert(pending_words.size(), w);
        w.idx = 4'd15; w.id = 64'h1; w.kvu = 20'd5; w.kvc = 20'd3; w.slu = 0; w.slc = 2;
        pending_words.insert(pending_words.size(), w);
        w.idx = 4'd1; w.id = 64'hA5A5; w.kvu = 0; w.kvc = 0; w.slu = 0; w.slc = 0;
        pending_words.insert(pending_words.size(), w);
        w.idx = 4'd2; w.id = 64'h2; w.kvu = 1; w.kvc = 10; w.slu = 0; w.slc = 1;
        pending_words.insert(pending_words.size(), w);
        w.idx = 4'd3; w.id = 64'h3; w.kvu = 9; w.kvc = 10; w.slu = 0; w.slc = 3;
        pending_words.insert(pending_words.size(), w);
        add_commit(5'd31);
        add_overlap(3, '1);
        add_sched('1);
        add_sched(20'd63);
        add_commit(5'd2);
        add_sched(20'd64);
        add_commit(5'd4);
        add_overlap(2, 20'd1);
        add_sched(20'd0);
        add_sched(20'd1000);
        add_sched(20'd1000);
        add_sched(20'd1000);
        wait_drained();

        foreach (bs_list[p]) begin
            write_block_size(bs_list[p]);
            n_words = 0;
            while (n_words < 190) begin
                if ($urandom_range(0, 9) == 0) begin
                    w = blank_word(t_cmd'($urandom_range(0, 3)));
                    w.idx = IDX_W'($urandom); w.id = {$urandom, $urandom};
                    w.kvu = KV_W'($urandom); w.kvc = KV_W'($urandom);
                    w.slu = SL_W'($urandom); w.slc = SL_W'($urandom);
                    w.cnt = WCNT_W'($urandom); w.ov = OV_W'($urandom);
                    w.isl = ISL_W'($urandom);
                    pending_words.insert(pending_words.size(), w);
                    n_words++;
                end else begin
                    // Fill a table, commit it, then schedule with overlaps.
                    int cnt;
                    cnt = $urandom_range(1, 16);
                    for (int i = 0; i < cnt; i++) begin
                        if ($urandom_range(0, 2) != 0) begin
                            pending_words.insert(pending_words.size(), random_entry(i));
                            n_words++;
                        end
                    end
                    add_commit(WCNT_W'(cnt));
                    n_words++;
                    for (int s = $urandom_range(1, 4); s > 0; s--) begin
                        for (int k = $urandom_range(0, 3); k > 0; k--) begin
                            add_overlap($urandom_range(0, 15),
                                        OV_W'($urandom_range(0, 1) ? $urandom_range(0, 40)
                                                                   : $urandom));
                            n_words++;
                        end
                        add_sched(ISL_W'($urandom_range(0, 1) ? $urandom_range(0, 4000)
                                                              : $urandom));
                        n_words++;
                    end
                end
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
